// ===== rtl/mwss_pkg.sv =====
// Shared constants and types for the windowed maximum subarray sum block.
package mwss_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;

	// One cell for every entry age the window can hold, plus the window start.
	localparam int DQ_DEPTH = WINDOW_MAX + 1;
	// Index width: modular ages stay exact while 2^IDX_W > WINDOW_MAX + 1.
	localparam int IDX_W    = $clog2(WINDOW_MAX + 2);
	// Prefix width: live prefixes differ by at most DQ_DEPTH full-scale samples.
	localparam int PFX_W    = SAMPLE_BITS + $clog2(DQ_DEPTH) + 1;
	// Effective window width after clamping.
	localparam int WEFF_W   = $clog2(WINDOW_MAX + 1);

	localparam int CFG_W    = 7;
	localparam int BEST_W   = 23;
	localparam int OUT_W    = 22;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);

	// Register index, taken from paddr above the byte offset.
	localparam logic REG_WINDOW = 1'b0;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [PFX_W-1:0] pfx;
	} entry_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic             clear;
		logic             shift;
		logic             cmp;
		logic             push;
		logic [IDX_W-1:0] idx;
		logic [PFX_W-1:0] cur_pfx;
	} cell_ctl_t;

endpackage

// ===== rtl/max_window_subarray_sum.sv =====
// Top level of the windowed maximum subarray sum block: control, chain of deque cells, output.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+--------------------------------------------
//   s_*      | in        | s_tvalid/s_tready| s_tdata[15:0] sample, s_tlast last_sample
//   m_*      | out       | m_tvalid/m_tready| m_tdata[21:0] best_sum, m_tlast sequence_done
//   apb      | in/out    | psel/penable     | window_width at byte address 0, pready tied high
//
// One sample is taken per cycle while s_tready is high; its result is registered and shows in the next cycle.
// After reset the cells fill with the start entry before the first request is taken.
// When the window is narrowed, each cell entry that falls out beyond the first costs a shift
// of the chain toward the front, during which s_tready stays low.
// A result that is not taken holds m_tdata/m_tlast and stalls the input side.
// A request with s_tlast returns the prefix, index, deque and best sum to their reset values.
module max_window_subarray_sum (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample stream in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mwss_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                            s_tlast,   // last_sample
	// result stream out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mwss_pkg::M_TDATA_W-1:0]  m_tdata,   // [21:0] best_sum, [23:22] zero
	output logic                            m_tlast,   // sequence_done
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mwss_pkg::ADDR_W-1:0]     paddr,
	input  logic [mwss_pkg::DATA_W-1:0]     pwdata,
	output logic [mwss_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import mwss_pkg::*;

	logic [CFG_W-1:0]   win_q;
	logic [WEFF_W-1:0]  w_eff;
	logic               init_q;
	logic [PFX_W-1:0]   run_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [BEST_W-1:0] best_q;

	logic               out_valid_q;
	logic [OUT_W-1:0]   best_sum_q;
	logic               done_q;

	logic               accept;
	logic               trim;
	logic               cfg_wr;
	logic [IDX_W-1:0]   next_idx;
	logic [IDX_W-1:0]   age0;
	logic [IDX_W-1:0]   age1;
	logic               dead0;
	logic               dead1;
	logic signed [SAMPLE_BITS-1:0] x;
	logic [PFX_W-1:0]   cur_pfx;
	entry_t             front;
	logic signed [PFX_W-1:0] d;
	logic signed [BEST_W-1:0] best_nxt;
	cell_ctl_t          ctl;

	entry_t             cell_ent  [DQ_DEPTH];
	logic               cell_keep [DQ_DEPTH];

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_WINDOW) begin
			win_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_WINDOW: prdata = DATA_W'(win_q);
			default:    prdata = '0;
		endcase
	end

	// Clamp the window to 1..WINDOW_MAX.
	always_comb begin
		if (win_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (int'(win_q) > WINDOW_MAX) begin
			w_eff = WEFF_W'(WINDOW_MAX);
		end else begin
			w_eff = WEFF_W'(win_q);
		end
	end

	// ---------------- front of the deque ----------------
	// Ages are taken against the index the next sample will get.
	assign next_idx = idx_q + IDX_W'(1);
	assign age0     = next_idx - cell_ent[0].idx;
	assign age1     = next_idx - cell_ent[1].idx;
	assign dead0    = cell_ent[0].valid && (int'(age0) > int'(w_eff));
	assign dead1    = cell_ent[1].valid && (int'(age1) > int'(w_eff));

	// A sample drops at most one front entry; more than one means the window shrank,
	// so shift the chain one step per cycle until only the front cell is stale.
	assign trim     = !init_q && dead1;
	assign s_tready = !init_q && !dead1 && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// ---------------- prefix and best sum ----------------
	assign x       = s_tdata[SAMPLE_BITS-1:0];
	assign cur_pfx = run_q + {{(PFX_W - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
	assign front   = dead0 ? cell_ent[1] : cell_ent[0];
	assign d       = cur_pfx - front.pfx;
	assign best_nxt = (d > best_q) ? BEST_W'(d) : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			run_q  <= '0;
			idx_q  <= '0;
			best_q <= {1'b1, {(BEST_W-1){1'b0}}};
		end else begin
			init_q <= 1'b0;
			if (accept) begin
				if (s_tlast) begin
					// end of sequence: report first, then start over
					run_q  <= '0;
					idx_q  <= '0;
					best_q <= {1'b1, {(BEST_W-1){1'b0}}};
				end else begin
					run_q  <= cur_pfx;
					idx_q  <= next_idx;
					best_q <= best_nxt;
				end
			end
		end
	end

	// ---------------- cell chain ----------------
	always_comb begin
		ctl.clear   = init_q || (accept && s_tlast);
		ctl.shift   = accept ? dead0 : trim;
		ctl.cmp     = accept;
		ctl.push    = accept;
		ctl.idx     = next_idx;
		ctl.cur_pfx = cur_pfx;
	end

	for (genvar k = 0; k < DQ_DEPTH; k++) begin : g_cell
		entry_t nbr;
		logic   prev_keep;

		if (k == DQ_DEPTH - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_link
			assign nbr = cell_ent[k+1];
		end

		if (k == 0) begin : g_head
			assign prev_keep = 1'b1;
		end else begin : g_prev
			assign prev_keep = cell_keep[k-1];
		end

		mwss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.seed      (k == 0),
			.nbr       (nbr),
			.prev_keep (prev_keep),
			.ent       (cell_ent[k]),
			.keep      (cell_keep[k])
		);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_sum_q <= best_nxt[OUT_W-1:0];
			done_q     <= s_tlast;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(best_sum_q);
	assign m_tlast  = done_q;

endmodule

// ===== rtl/mwss_cell.sv =====
// One deque cell: holds an (index, prefix) entry, shifts toward the front and drops by compare.
module mwss_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mwss_pkg::cell_ctl_t ctl,
	input  logic               seed,
	input  mwss_pkg::entry_t   nbr,
	input  logic               prev_keep,
	output mwss_pkg::entry_t   ent,
	output logic               keep
);
	import mwss_pkg::*;

	logic             valid_q;
	logic [IDX_W-1:0] idx_q;
	logic [PFX_W-1:0] pfx_q;
	entry_t           cand;
	logic [PFX_W-1:0] diff;
	logic             push;

	assign ent  = {valid_q, idx_q, pfx_q};
	assign cand = ctl.shift ? nbr : ent;
	assign diff = cand.pfx - ctl.cur_pfx;
	// keep only entries strictly below the current prefix
	assign keep = cand.valid && (!ctl.cmp || diff[PFX_W-1]);
	assign push = ctl.push && prev_keep && !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= seed;
		end else begin
			valid_q <= keep || push;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			idx_q <= '0;
			pfx_q <= '0;
		end else if (push) begin
			idx_q <= ctl.idx;
			pfx_q <= ctl.cur_pfx;
		end else begin
			idx_q <= cand.idx;
			pfx_q <= cand.pfx;
		end
	end

endmodule

// ===== rtl/mwss_chk.sv =====
// Port-level checker for the windowed maximum subarray sum block, bound to the top level.
module mwss_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mwss_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                            m_tlast,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [mwss_pkg::ADDR_W-1:0]     paddr,
	input logic [mwss_pkg::DATA_W-1:0]     pwdata,
	input logic [mwss_pkg::DATA_W-1:0]     prdata,
	input logic                            pready
);
	import mwss_pkg::*;

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// every request yields a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("request without result");

	// a pending result that is not taken blocks new requests
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken over a stalled result");

	// window register reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr == '0
		|=> paddr != '0 || prdata == DATA_W'($past(pwdata[CFG_W-1:0])))
		else $error("window register readback mismatch");

endmodule

bind max_window_subarray_sum mwss_chk u_mwss_chk (.*);
